FILE: sv/scsa_pkg.sv
package scsa_pkg;

  // Pool geometry; slot count per pool is a power of two, at least one map word.
  localparam int SlotsPerPool = 1024;
  localparam int PoolCount    = 3;
  localparam int ClassCount   = 3;

  localparam int SLOT_W  = $clog2(SlotsPerPool);
  localparam int POOL_W  = (PoolCount > 1) ? $clog2(PoolCount) : 1;
  localparam int WORD_W  = (SlotsPerPool < 32) ? SlotsPerPool : 32;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WORDS   = SlotsPerPool / WORD_W;
  localparam int WIDX_W  = (SLOT_W > BIT_W) ? SLOT_W - BIT_W : 1;
  localparam int ROWS    = PoolCount * WORDS;
  localparam int ROW_AW  = POOL_W + WIDX_W;

  // Result status codes
  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StUnpooled = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StNonPool  = 2'd3;

  // Register indexes
  localparam logic [1:0] RegClassFirst  = 2'd0;
  localparam logic [1:0] RegClassSecond = 2'd1;
  localparam logic [1:0] RegClassThird  = 2'd2;

  localparam logic [15:0] ClassFirstRst  = 16'd92;
  localparam logic [15:0] ClassSecondRst = 16'd12;
  localparam logic [15:0] ClassThirdRst  = 16'd26;

  typedef struct packed {
    logic                rd_en;
    logic [ROW_AW-1:0]   rd_addr;
    logic                wr_en;
    logic [ROW_AW-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
  } bm_req_t;

  // Index of the lowest set bit.
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: sv/scsa_bitmap.sv
module scsa_bitmap
  import scsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bm_req_t           req_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] mem_q [ROWS];
  logic [ROWS-1:0]   row_vld_q;
  logic [WORD_W-1:0] rd_word_q;
  logic              rd_vld_q;

  // Used-bit words; a row never written reads as all free.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_word_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_word_q : '0;

endmodule

FILE: sv/size_class_slot_allocator.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | operation, request_size, release_pool/slot
// out     | output    | out_valid_o/out_stall_i | status, pool_id, slot_index
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Allocate: straight to done if the size has no class, else one read per 32-bit map word
// (up to 33 words: start word twice); the map has a single read port for these reads.
// Release: read-modify-write of one word; a handle that names no pool goes straight to done.
// Reset clears every slot at once through per-word valid bits; no sweep.
// The result register lets one finished result wait while the next request runs; a
// second result holds in the done state until the output drains.
module size_class_slot_allocator
  import scsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] request_size_i,
  input  logic [1:0]  release_pool_i,
  input  logic [9:0]  release_slot_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [1:0]  pool_id_o,
  output logic [9:0]  slot_index_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int KW = $clog2(WORDS + 2);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_REL_RD = 3'd2;
  localparam logic [2:0] S_REL_WR = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [15:0]       class_size_q [ClassCount];
  logic [SLOT_W-1:0] next_search_q [PoolCount];

  // current request
  logic [POOL_W-1:0] pool_q, pool_d;
  logic [SLOT_W-1:0] start_q, start_d;   // search start, or released slot
  logic [KW-1:0]     k_rd_q, k_rd_d;     // next word offset to read
  logic [KW-1:0]     k_chk_q;            // offset of word now on read data
  logic              chk_v_q;

  // result held for the output register
  logic [1:0]        res_status_q, res_status_d;
  logic [POOL_W-1:0] res_pool_q, res_pool_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [1:0]        out_pool_q;
  logic [9:0]        out_slot_q;

  bm_req_t           bm_req;
  logic [WORD_W-1:0] rd_data;

  logic              accept;
  logic              out_free;
  logic              issue;
  logic [WIDX_W-1:0] w0;
  logic [BIT_W-1:0]  b0;
  logic [WORD_W-1:0] lo_mask, chk_mask, free_bits, bit_sel;
  logic [BIT_W-1:0]  free_pos;
  logic [WIDX_W-1:0] chk_word;
  logic              match_hit;
  logic [POOL_W-1:0] match_pool;
  logic              rel_ok;
  logic              ptr_we;
  logic [SLOT_W-1:0] ptr_val;

  scsa_bitmap u_bitmap (
    .clk_i,
    .rst_ni,
    .req_i     (bm_req),
    .rd_data_o (rd_data)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign pool_id_o    = out_pool_q;
  assign slot_index_o = out_slot_q;

  // Class lookup: lowest numbered matching pool wins.
  always_comb begin
    match_hit  = 1'b0;
    match_pool = '0;
    for (int c = ClassCount - 1; c >= 0; c--) begin
      if (c < PoolCount && class_size_q[c] == request_size_i) begin
        match_hit  = 1'b1;
        match_pool = POOL_W'(c);
      end
    end
  end

  assign rel_ok = (release_pool_i != 2'd3) && (32'(release_pool_i) < PoolCount);

  // Next-fit word masks: first word from the start bit up, wrapped last word below it.
  assign w0       = start_q[SLOT_W-1:BIT_W];
  assign b0       = start_q[BIT_W-1:0];
  assign lo_mask  = (WORD_W'(1) << b0) - WORD_W'(1);
  always_comb begin
    if (k_chk_q == '0) begin
      chk_mask = ~lo_mask;
    end else if (k_chk_q == KW'(WORDS)) begin
      chk_mask = lo_mask;
    end else begin
      chk_mask = '1;
    end
  end
  assign free_bits = ~rd_data & chk_mask;
  assign free_pos  = first_set(free_bits);
  assign chk_word  = w0 + k_chk_q[WIDX_W-1:0];
  assign issue     = (state_q == S_SCAN) && (k_rd_q <= KW'(WORDS));
  assign bit_sel   = WORD_W'(1) << ((state_q == S_SCAN) ? free_pos : start_q[BIT_W-1:0]);

  always_comb begin
    state_d      = state_q;
    pool_d       = pool_q;
    start_d      = start_q;
    k_rd_d       = k_rd_q;
    res_status_d = res_status_q;
    res_pool_d   = res_pool_q;
    res_slot_d   = res_slot_q;
    ptr_we       = 1'b0;
    ptr_val      = start_q + SLOT_W'(1);
    bm_req       = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          k_rd_d = '0;
          if (operation_i) begin
            if (rel_ok) begin
              pool_d  = POOL_W'(release_pool_i);
              start_d = SLOT_W'(release_slot_i);
              state_d = S_REL_RD;
            end else begin
              res_status_d = StNonPool;
              res_pool_d   = '0;
              res_slot_d   = '0;
              state_d      = S_DONE;
            end
          end else if (match_hit) begin
            pool_d  = match_pool;
            start_d = next_search_q[match_pool];
            state_d = S_SCAN;
          end else begin
            res_status_d = StUnpooled;
            res_pool_d   = '0;
            res_slot_d   = '0;
            state_d      = S_DONE;
          end
        end
      end
      S_SCAN: begin
        bm_req.rd_en   = issue;
        bm_req.rd_addr = {pool_q, w0 + k_rd_q[WIDX_W-1:0]};
        if (issue) begin
          k_rd_d = k_rd_q + KW'(1);
        end
        if (chk_v_q && free_bits != '0) begin
          // claim the slot in the same cycle
          bm_req.wr_en   = 1'b1;
          bm_req.wr_addr = {pool_q, chk_word};
          bm_req.wr_data = rd_data | bit_sel;
          res_status_d   = StDone;
          res_pool_d     = pool_q;
          res_slot_d     = {chk_word, free_pos};
          ptr_we         = 1'b1;
          ptr_val        = {chk_word, free_pos} + SLOT_W'(1);
          state_d        = S_DONE;
        end else if (chk_v_q && k_chk_q == KW'(WORDS)) begin
          // pool full: pointer moves on by one
          res_status_d = StFull;
          res_pool_d   = pool_q;
          res_slot_d   = '0;
          ptr_we       = 1'b1;
          ptr_val      = start_q + SLOT_W'(1);
          state_d      = S_DONE;
        end
      end
      S_REL_RD: begin
        bm_req.rd_en   = 1'b1;
        bm_req.rd_addr = {pool_q, start_q[SLOT_W-1:BIT_W]};
        state_d        = S_REL_WR;
      end
      S_REL_WR: begin
        bm_req.wr_en   = 1'b1;
        bm_req.wr_addr = {pool_q, start_q[SLOT_W-1:BIT_W]};
        bm_req.wr_data = rd_data & ~bit_sel;
        res_status_d   = StDone;
        res_pool_d     = pool_q;
        res_slot_d     = start_q;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      class_size_q[0] <= ClassFirstRst;
      class_size_q[1] <= ClassSecondRst;
      class_size_q[2] <= ClassThirdRst;
      for (int p = 0; p < PoolCount; p++) begin
        next_search_q[p] <= '0;
      end
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegClassFirst:  class_size_q[0] <= cfg_data_i;
          RegClassSecond: class_size_q[1] <= cfg_data_i;
          RegClassThird:  class_size_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (ptr_we) begin
        next_search_q[pool_q] <= ptr_val;
      end
      chk_v_q <= issue;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pool_q       <= pool_d;
    start_q      <= start_d;
    k_rd_q       <= k_rd_d;
    k_chk_q      <= k_rd_q;
    res_status_q <= res_status_d;
    res_pool_q   <= res_pool_d;
    res_slot_q   <= res_slot_d;
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_pool_q   <= 2'(res_pool_q);
      out_slot_q   <= 10'(res_slot_q);
    end
  end

endmodule

FILE: sim/slot_ledger_pkg.sv
`timescale 1ns / 1ps

package slot_ledger_pkg;
  import scsa_pkg::*;

  // request opcodes and the pool code that names no pool
  localparam logic       OpAlloc   = 1'b0;
  localparam logic       OpRelease = 1'b1;
  localparam logic [1:0] PoolNone  = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] pool;
    logic [9:0] slot;
  } slot_grant_t;

  // Tracks slot occupancy and search pointers, and holds the grants still owed.
  class slot_ledger;
    logic [15:0]  class_size [ClassCount];
    bit           slot_busy  [PoolCount][SlotsPerPool];
    int unsigned  search_ptr [PoolCount];
    slot_grant_t  owed_results [$];
    int unsigned  fail_count;

    function new();
      class_size[RegClassFirst]  = ClassFirstRst;
      class_size[RegClassSecond] = ClassSecondRst;
      class_size[RegClassThird]  = ClassThirdRst;
      foreach (slot_busy[p, s]) slot_busy[p][s] = 1'b0;
      foreach (search_ptr[p]) search_ptr[p] = 0;
      fail_count = 0;
    endfunction

    function void set_class_size(input logic [1:0] idx, input logic [15:0] value);
      if (idx < ClassCount) class_size[idx] = value;
    endfunction

    // Applies one request to the occupancy map and returns the grant it yields.
    function slot_grant_t settle_request(input logic op, input logic [15:0] size,
                                         input logic [1:0] rpool,
                                         input logic [9:0] rslot);
      slot_grant_t grant;
      int          pool;
      int unsigned idx;
      int unsigned start;
      bit          hit;
      grant = '{status: StUnpooled, pool: 2'd0, slot: 10'd0};
      if (op == OpRelease) begin
        if (rpool == PoolNone || rpool >= PoolCount || rslot >= SlotsPerPool) begin
          grant.status = StNonPool;
        end else begin
          slot_busy[rpool][rslot] = 1'b0;
          grant = '{status: StDone, pool: rpool, slot: rslot};
        end
        return grant;
      end
      // lowest matching class wins
      pool = -1;
      for (int c = 0; c < ClassCount; c++) begin
        if (pool < 0 && c < PoolCount && class_size[c] == size) pool = c;
      end
      if (pool < 0) return grant;
      start = search_ptr[pool] % SlotsPerPool;
      hit   = 1'b0;
      for (int unsigned j = 0; j < SlotsPerPool; j++) begin
        idx = (start + j) % SlotsPerPool;
        if (!hit && !slot_busy[pool][idx]) begin
          hit = 1'b1;
          slot_busy[pool][idx] = 1'b1;
          search_ptr[pool] = (idx + 1) % SlotsPerPool;
          grant = '{status: StDone, pool: 2'(pool), slot: 10'(idx)};
        end
      end
      if (!hit) begin
        search_ptr[pool] = (start + 1) % SlotsPerPool;
        grant = '{status: StFull, pool: 2'(pool), slot: 10'd0};
      end
      return grant;
    endfunction

    function slot_grant_t note_request(input logic op, input logic [15:0] size,
                                       input logic [1:0] rpool,
                                       input logic [9:0] rslot);
      slot_grant_t grant;
      grant = settle_request(op, size, rpool, rslot);
      owed_results.push_back(grant);
      return grant;
    endfunction

    function void check_result(input logic [1:0] status, input logic [1:0] pool,
                               input logic [9:0] slot);
      slot_grant_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing owed: status %0d pool %0d slot %0d",
                 $time, status, pool, slot);
        fail_count++;
        return;
      end
      want = owed_results.pop_front();
      if (status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
        fail_count++;
      end
      if (pool !== want.pool) begin
        $display("%0t: pool_id expected %0d, got %0d", $time, want.pool, pool);
        fail_count++;
      end
      if (slot !== want.slot) begin
        $display("%0t: slot_index expected %0d, got %0d", $time, want.slot, slot);
        fail_count++;
      end
    endfunction
  endclass

endpackage

FILE: sim/size_class_slot_allocator_test.sv
`timescale 1ns / 1ps

module size_class_slot_allocator_test;
  import scsa_pkg::*;
  import slot_ledger_pkg::*;

  // The longest quiet stretch of a correct run is the forced receiver hold-off
  // below, so the watchdog limit sits well above that.
  localparam int HalfPeriod    = 4;
  localparam int ResetCycles   = 4;
  localparam int HoldOffCycles = 400;
  localparam int QuietLimit    = 3000;
  localparam int SettleCycles  = 8;
  localparam int DrainCycles   = 40;
  localparam int PhaseItems    = 80;
  localparam int FillAllocs    = 64;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        operation_i    = OpAlloc;
  logic [15:0] request_size_i = '0;
  logic [1:0]  release_pool_i = '0;
  logic [9:0]  release_slot_i = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [1:0]  status_o;
  logic [1:0]  pool_id_o;
  logic [9:0]  slot_index_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i    = '0;
  logic [15:0] cfg_data_i     = '0;

  slot_ledger  ledger = new();
  slot_grant_t held_slots [$];   // handles granted and not yet handed back
  int          sender_idle_pct    = 0;
  int          receiver_stall_pct = 0;
  int          hold_left          = 0;
  int          quiet_cycles       = 0;

  size_class_slot_allocator i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .request_size_i,
    .release_pool_i,
    .release_slot_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .pool_id_o,
    .slot_index_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Result side: stall decided at the falling edge, so it is stable by the
  // rising edge; a forced hold-off takes priority over random stalls.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      ledger.check_result(status_o, pool_id_o, slot_index_o);
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one request, with random idle cycles first. Valid stays high after
  // the accepting edge; the next call changes it at the following falling edge.
  task automatic send_request(input logic op, input logic [15:0] size,
                              input logic [1:0] pool, input logic [9:0] slot);
    slot_grant_t grant;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     = 1'b1;
    operation_i    = op;
    request_size_i = size;
    release_pool_i = pool;
    release_slot_i = slot;
    do @(posedge clk_i); while (in_stall_o);
    grant = ledger.note_request(op, size, pool, slot);
    if (op == OpAlloc && grant.status == StDone) held_slots.push_back(grant);
  endtask

  task automatic alloc_bytes(input logic [15:0] size);
    send_request(OpAlloc, size, 2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)));
  endtask

  task automatic release_slot(input logic [1:0] pool, input logic [9:0] slot);
    send_request(OpRelease, 16'($urandom_range(0, 65535)), pool, slot);
  endtask

  // Register writes only happen with the block drained.
  task automatic write_class(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.set_class_size(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_classes(input logic [15:0] first, input logic [15:0] second,
                             input logic [15:0] third);
    write_class(RegClassFirst, first);
    write_class(RegClassSecond, second);
    write_class(RegClassThird, third);
  endtask

  // Sender pause: drop valid and wait for every owed result.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (ledger.owed_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic: allocations of configured sizes and releases
  // of handles actually held; the rest are odd sizes and arbitrary handles.
  task automatic random_request();
    int          pick;
    int          k;
    slot_grant_t h;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      alloc_bytes(ledger.class_size[$urandom_range(0, ClassCount - 1)]);
    end else if (pick < 65) begin
      alloc_bytes(16'($urandom_range(0, 65535)));
    end else if (pick < 92 && held_slots.size() > 0) begin
      k = $urandom_range(0, held_slots.size() - 1);
      h = held_slots[k];
      held_slots.delete(k);
      release_slot(h.pool, h.slot);
    end else begin
      release_slot(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)));
    end
  endtask

  task automatic random_phase(input int count);
    repeat (count) random_request();
  endtask

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, reset class sizes 92 / 12 / 26.
    alloc_bytes(16'd92);                // pool 0, slot 0
    alloc_bytes(16'd12);                // pool 1, slot 0
    alloc_bytes(16'd26);                // pool 2, slot 0
    alloc_bytes(16'd26);                // pool 2, slot 1
    alloc_bytes(16'd0);                 // no class
    alloc_bytes(16'hFFFF);
    alloc_bytes(16'd93);
    alloc_bytes(16'hAAAA);
    alloc_bytes(16'h5555);
    release_slot(2'd2, 10'd0);
    release_slot(2'd2, 10'd0);          // already free, still reported done
    alloc_bytes(16'd26);                // next fit goes past the hole: slot 2
    release_slot(PoolNone, 10'd1023);   // not a pool handle
    release_slot(PoolNone, 10'd0);
    release_slot(2'd0, 10'd1023);
    release_slot(2'd1, 10'd0);
    release_slot(2'd1, 10'h2AA);
    release_slot(2'd0, 10'h155);
    wait_idle();

    // Extreme sizes; first and third equal, so pool zero takes both.
    set_classes(16'd0, 16'hFFFF, 16'd0);
    alloc_bytes(16'd0);
    alloc_bytes(16'hFFFF);
    alloc_bytes(16'd0);
    alloc_bytes(16'd92);
    wait_idle();

    // Run pool one forward over a few map words, punch holes behind the
    // search pointer, then allocate on.
    set_classes(16'd92, 16'd12, 16'd26);
    sender_idle_pct    = 11;
    receiver_stall_pct = 11;
    repeat (FillAllocs) alloc_bytes(16'd12);
    repeat (16) release_slot(2'd1, 10'($urandom_range(0, FillAllocs - 1)));
    repeat (24) alloc_bytes(16'd12);
    wait_idle();

    // No idling; includes a long receiver hold-off while requests keep coming.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    set_classes(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
    random_phase(PhaseItems / 2);
    hold_left = HoldOffCycles;
    random_phase(PhaseItems / 2);
    wait_idle();

    // Sender idle, all classes equal: pool zero serves everything.
    sender_idle_pct = 48;
    set_classes(16'd7, 16'd7, 16'd7);
    random_phase(PhaseItems);
    wait_idle();

    // Receiver stalling, extreme sizes again.
    sender_idle_pct    = 0;
    receiver_stall_pct = 48;
    set_classes(16'hFFFF, 16'd0, 16'hFFFF);
    random_phase(PhaseItems);
    wait_idle();

    // Both sides idle a little; tiny sizes so classes often coincide.
    sender_idle_pct    = 11;
    receiver_stall_pct = 11;
    set_classes(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                16'($urandom_range(0, 3)));
    random_phase(PhaseItems);

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (ledger.fail_count == 0 && ledger.owed_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
